### sv/hamenc_pkg.sv
`default_nettype none

package hamenc_pkg;

  localparam int unsigned MSG_W  = 57;
  localparam int unsigned POS_W  = 63;
  localparam int unsigned CW_W   = 64;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned DLEN_W = 6;
  localparam int unsigned PAR_W  = 6;
  localparam int unsigned PCNT_W = 3;

  localparam logic CFG_DATA_LENGTH   = 1'b0;
  localparam logic CFG_EXTENDED_MODE = 1'b1;

  localparam logic [DLEN_W-1:0] DATA_LENGTH_RST   = 6'd4;
  localparam logic              EXTENDED_MODE_RST = 1'b0;

  typedef logic [POS_W-1:0] pos_word_t;

  // Data bits fill the positions that are not powers of two, lowest first.
  function automatic pos_word_t scatter(input logic [MSG_W-1:0] msg);
    pos_word_t   cw;
    logic [5:0]  dp;
    cw = '0;
    dp = '0;
    for (int pos = 1; pos <= POS_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        cw[pos-1] = msg[dp];
        dp        = dp + 6'd1;
      end
    end
    return cw;
  endfunction

  // Parity bit k covers every position whose 1-based index has bit k set.
  function automatic logic [PAR_W-1:0] parity_bits(input pos_word_t cw);
    logic [PAR_W-1:0] par;
    par = '0;
    for (int k = 0; k < PAR_W; k++) begin
      for (int j = 1; j <= POS_W; j++) begin
        if (((j >> k) & 1) != 0) begin
          par[k] = par[k] ^ cw[j-1];
        end
      end
    end
    return par;
  endfunction

  function automatic pos_word_t insert_parity(input pos_word_t cw,
                                              input logic [PAR_W-1:0] par);
    pos_word_t res;
    res = cw;
    for (int k = 0; k < PAR_W; k++) begin
      res[(1 << k) - 1] = par[k];
    end
    return res;
  endfunction

  function automatic logic [PCNT_W-1:0] parity_count(input logic [DLEN_W-1:0] m);
    logic [PCNT_W-1:0] p;
    if (m <= 6'd1) begin
      p = 3'd2;
    end else if (m <= 6'd4) begin
      p = 3'd3;
    end else if (m <= 6'd11) begin
      p = 3'd4;
    end else if (m <= 6'd26) begin
      p = 3'd5;
    end else begin
      p = 3'd6;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### sv/hamming_encoder_variable_length_top.sv
// Channel  | Direction | Ports                                   | Handshake
// ---------+-----------+-----------------------------------------+--------------------
// input    | in        | message_word_i                          | start && !busy
// result   | out       | codeword_o, codeword_length_o           | done_o, one cycle
// config   | in        | cfg_index_i, cfg_data_i                 | cfg_we_i
//
// An accepted word passes through three register stages before done_o rises:
// length masking, data scatter and parity trees, then overall parity.
// A new word is accepted in every cycle; busy stays low.
// Reset clears the stage valid bits and restores the configuration defaults.
// The receiver cannot stall, so every result is shown for exactly one cycle.
`default_nettype none

module hamming_encoder_variable_length_top #(
  parameter int unsigned MAX_DATA_BITS = 57
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [hamenc_pkg::MSG_W-1:0]        message_word_i,
  output logic                                     done_o,
  output logic      [hamenc_pkg::CW_W-1:0]         codeword_o,
  output logic      [hamenc_pkg::LEN_W-1:0]        codeword_length_o,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_index_i,
  input  wire logic [hamenc_pkg::DLEN_W-1:0]       cfg_data_i
);

  localparam int unsigned MSG_W  = hamenc_pkg::MSG_W;
  localparam int unsigned DLEN_W = hamenc_pkg::DLEN_W;
  localparam int unsigned LEN_W  = hamenc_pkg::LEN_W;

  logic [DLEN_W-1:0] data_length_q;
  logic              extended_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_length_q   <= hamenc_pkg::DATA_LENGTH_RST;
      extended_mode_q <= hamenc_pkg::EXTENDED_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hamenc_pkg::CFG_DATA_LENGTH:   data_length_q   <= cfg_data_i;
        hamenc_pkg::CFG_EXTENDED_MODE: extended_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                  accept;
  logic [DLEN_W-1:0]     m_eff;
  logic [MSG_W-1:0]      msg_mask;
  logic [DLEN_W-1:0]     n_d;

  assign accept = start && !busy;

  always_comb begin
    if (data_length_q == '0) begin
      m_eff = DLEN_W'(1);
    end else if (data_length_q > DLEN_W'(MAX_DATA_BITS)) begin
      m_eff = DLEN_W'(MAX_DATA_BITS);
    end else begin
      m_eff = data_length_q;
    end
    msg_mask = (MSG_W'(1) << m_eff) - MSG_W'(1);
    n_d      = m_eff + DLEN_W'(hamenc_pkg::parity_count(m_eff));
  end

  logic                  s1_valid_q;
  logic [MSG_W-1:0]      s1_msg_q;
  logic [DLEN_W-1:0]     s1_n_q;
  logic                  s1_ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_msg_q <= message_word_i & msg_mask;
      s1_n_q   <= n_d;
      s1_ext_q <= extended_mode_q;
    end
  end

  hamenc_pkg::pos_word_t s1_scat;
  hamenc_pkg::pos_word_t s2_cw_d;

  always_comb begin
    s1_scat = hamenc_pkg::scatter(s1_msg_q);
    s2_cw_d = hamenc_pkg::insert_parity(s1_scat, hamenc_pkg::parity_bits(s1_scat));
  end

  logic                  s2_valid_q;
  hamenc_pkg::pos_word_t s2_cw_q;
  logic [DLEN_W-1:0]     s2_n_q;
  logic                  s2_ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_cw_q  <= s2_cw_d;
      s2_n_q   <= s1_n_q;
      s2_ext_q <= s1_ext_q;
    end
  end

  logic                       overall;
  logic [hamenc_pkg::CW_W-1:0] cw_d;
  logic [LEN_W-1:0]           len_d;

  always_comb begin
    overall = ^s2_cw_q;
    if (s2_ext_q) begin
      cw_d = {s2_cw_q, overall};
    end else begin
      cw_d = {1'b0, s2_cw_q};
    end
    len_d = {1'b0, s2_n_q} + LEN_W'(s2_ext_q);
  end

  logic                        done_q;
  logic [hamenc_pkg::CW_W-1:0] codeword_q;
  logic [LEN_W-1:0]            codeword_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      codeword_q        <= cw_d;
      codeword_length_q <= len_d;
    end
  end

  assign done_o            = done_q;
  assign codeword_o        = codeword_q;
  assign codeword_length_o = codeword_length_q;

endmodule

`default_nettype wire
